/* rtl/core/bec_pkg.sv */
// ----------------------------------------------------------------------------
// bec_pkg
// Shared types, character codes and helpers for the backslash escape codec.
// ----------------------------------------------------------------------------
package bec_pkg;

  localparam int unsigned SLOTS = 4;
  localparam int unsigned CNT_W = 3;

  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_LO_N  = 8'h6E;
  localparam logic [7:0] CH_LO_R  = 8'h72;
  localparam logic [7:0] CH_LO_T  = 8'h74;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;

  localparam logic MODE_DECODE = 1'b0;
  localparam logic MODE_ENCODE = 1'b1;

  // One accepted item, classified: up to four bytes, a byte count and the end flag.
  // A count of zero with text_end set stands for a bare end marker.
  typedef struct packed {
    logic [SLOTS-1:0][7:0] bytes;
    logic [CNT_W-1:0]      cnt;
    logic                  text_end;
  } bec_bundle_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } bec_digit_t;

  function automatic bec_digit_t hex_of(input logic [7:0] c);
    bec_digit_t d;
    d = '{ok: 1'b0, val: 4'h0};
    if (c >= CH_0 && c <= CH_9) begin
      d = '{ok: 1'b1, val: 4'(c - CH_0)};
    end else if (c >= CH_LO_A && c <= CH_LO_F) begin
      d = '{ok: 1'b1, val: 4'(c - CH_LO_A + 8'd10)};
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      d = '{ok: 1'b1, val: 4'(c - CH_UP_A + 8'd10)};
    end
    return d;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [7:0] read_pair(input logic [7:0] a, input logic [7:0] b);
    bec_digit_t ha;
    bec_digit_t hb;
    logic [7:0] v;
    ha = hex_of(a);
    hb = hex_of(b);
    v  = 8'h00;
    if (ha.ok) begin
      v = hb.ok ? {ha.val, hb.val} : {4'h0, ha.val};
    end else if (is_blank(a) || a == CH_PLUS) begin
      v = hb.ok ? {4'h0, hb.val} : 8'h00;
    end else if (a == CH_MINUS) begin
      v = hb.ok ? (8'h00 - {4'h0, hb.val}) : 8'h00;
    end
    return v;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (CH_0 + {4'h0, n}) : (CH_LO_A + {4'h0, n} - 8'd10);
  endfunction

endpackage

/* rtl/core/bec_ifs.sv */
// ----------------------------------------------------------------------------
// bec_ifs
// Valid/ready channels of the escape codec: input text, result and mode write.
// ----------------------------------------------------------------------------
interface bec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       text_end;

  modport source (output valid, in_byte, text_end, input ready);
  modport sink   (input valid, in_byte, text_end, output ready);
endinterface

interface bec_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic       text_done;

  modport source (output valid, out_byte, byte_valid, run_last, text_done, input ready);
  modport sink   (input valid, out_byte, byte_valid, run_last, text_done, output ready);
endinterface

interface bec_cfg_if;
  logic valid;
  logic ready;
  logic mode;

  modport source (output valid, mode, input ready);
  modport sink   (input valid, mode, output ready);
endinterface

/* rtl/core/backslash_escape_codec.sv */
// ----------------------------------------------------------------------------
// backslash_escape_codec
// Byte-stream codec for C-style backslash escapes, decode or encode by mode.
// ----------------------------------------------------------------------------
// The input side takes one text byte per cycle whenever the bundle queue has
// room; the front classifies it in the cycle it is accepted. The result side
// gives one result per cycle while the output is ready: each result byte of an
// item in turn, or a single result with byte_valid low for a bare end marker;
// the output port sets the sustained rate, one byte per cycle for plain text.
// Each item is queued at the accepting edge and then loaded from the queue head
// into the output register. Write mode only while idle; a mode write drops
// any open escape.
module backslash_escape_codec
  import bec_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  bec_in_if.sink   in_ch,
  bec_out_if.source out_ch,
  bec_cfg_if.sink  cfg_ch
);

  logic        push, push_ready, q_valid, q_pop;
  bec_bundle_t push_data, q_data;

  bec_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_byte    (in_ch.in_byte),
    .text_end   (in_ch.text_end),
    .cfg_valid  (cfg_ch.valid),
    .cfg_ready  (cfg_ch.ready),
    .cfg_mode   (cfg_ch.mode),
    .push       (push),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  bec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  bec_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_data     (q_data),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_byte   (out_ch.out_byte),
    .byte_valid (out_ch.byte_valid),
    .run_last   (out_ch.run_last),
    .text_done  (out_ch.text_done)
  );

endmodule

/* rtl/core/bec_front.sv */
// ----------------------------------------------------------------------------
// bec_front
// Accept text items, track the escape state and classify each item into a
// bundle of up to four result bytes.
// ----------------------------------------------------------------------------
module bec_front
  import bec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        text_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_mode,
  output logic        push,
  input  logic        push_ready,
  output bec_bundle_t push_data
);

  localparam logic [1:0] PH_PLAIN = 2'd0;
  localparam logic [1:0] PH_BSL   = 2'd1;
  localparam logic [1:0] PH_X     = 2'd2;
  localparam logic [1:0] PH_HEX   = 2'd3;

  logic       mode_r;
  logic [1:0] phase_r, phase_nxt;
  logic [7:0] held_x_r, held_x_nxt;
  logic [7:0] held_hex_r, held_hex_nxt;
  logic       accept;
  logic [7:0] pair_val;
  bec_bundle_t bnd;

  assign in_ready  = push_ready;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign pair_val  = read_pair(held_hex_r, in_byte);

  always_comb begin
    bnd          = '0;
    bnd.text_end = text_end;
    phase_nxt    = phase_r;
    held_x_nxt   = held_x_r;
    held_hex_nxt = held_hex_r;
    if (mode_r == MODE_ENCODE) begin
      priority if (in_byte == CH_LF) begin
        bnd.bytes[0] = CH_BSL; bnd.bytes[1] = CH_LO_N; bnd.cnt = 3'd2;
      end else if (in_byte == CH_CR) begin
        bnd.bytes[0] = CH_BSL; bnd.bytes[1] = CH_LO_R; bnd.cnt = 3'd2;
      end else if (in_byte == CH_TAB) begin
        bnd.bytes[0] = CH_BSL; bnd.bytes[1] = CH_LO_T; bnd.cnt = 3'd2;
      end else if (in_byte == CH_BSL) begin
        bnd.bytes[0] = CH_BSL; bnd.bytes[1] = CH_BSL; bnd.cnt = 3'd2;
      end else if (in_byte >= CH_SPACE && in_byte <= CH_TILDE) begin
        bnd.bytes[0] = in_byte; bnd.cnt = 3'd1;
      end else begin
        bnd.bytes[0] = CH_BSL;
        bnd.bytes[1] = CH_LO_X;
        bnd.bytes[2] = hex_char(in_byte[7:4]);
        bnd.bytes[3] = hex_char(in_byte[3:0]);
        bnd.cnt      = 3'd4;
      end
    end else begin
      unique case (phase_r)
        PH_PLAIN: begin
          if (in_byte == CH_BSL) begin
            phase_nxt = PH_BSL;
          end else if (in_byte != 8'h00) begin
            bnd.bytes[0] = in_byte; bnd.cnt = 3'd1;
          end
        end
        PH_BSL: begin
          phase_nxt = PH_PLAIN;
          priority if (in_byte == CH_LO_N) begin
            bnd.bytes[0] = CH_LF; bnd.cnt = 3'd1;
          end else if (in_byte == CH_LO_R) begin
            bnd.bytes[0] = CH_CR; bnd.cnt = 3'd1;
          end else if (in_byte == CH_LO_T) begin
            bnd.bytes[0] = CH_TAB; bnd.cnt = 3'd1;
          end else if (in_byte == CH_BSL) begin
            bnd.bytes[0] = CH_BSL; bnd.cnt = 3'd1;
          end else if (in_byte == CH_LO_X || in_byte == CH_UP_X) begin
            held_x_nxt = in_byte;
            phase_nxt  = PH_X;
          end else begin
            bnd.bytes[0] = CH_BSL;
            bnd.bytes[1] = in_byte;
            bnd.cnt      = (in_byte != 8'h00) ? 3'd2 : 3'd1;
          end
        end
        PH_X: begin
          held_hex_nxt = in_byte;
          phase_nxt    = PH_HEX;
        end
        PH_HEX: begin
          phase_nxt = PH_PLAIN;
          if (pair_val != 8'h00) begin
            bnd.bytes[0] = pair_val; bnd.cnt = 3'd1;
          end
        end
        default: phase_nxt = PH_PLAIN;
      endcase
      // flush an escape cut off by the end of the text
      if (text_end && phase_nxt != PH_PLAIN) begin
        bnd.bytes[0] = CH_BSL;
        bnd.cnt      = 3'd1;
        if (phase_nxt == PH_X || phase_nxt == PH_HEX) begin
          bnd.bytes[1] = held_x_nxt;
          bnd.cnt      = 3'd2;
        end
        if (phase_nxt == PH_HEX && held_hex_nxt != 8'h00) begin
          bnd.bytes[2] = held_hex_nxt;
          bnd.cnt      = 3'd3;
        end
        phase_nxt = PH_PLAIN;
      end
    end
  end

  assign push      = accept && (bnd.cnt != 3'd0 || text_end);
  assign push_data = bnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_DECODE;
      phase_r    <= PH_PLAIN;
      held_x_r   <= 8'h00;
      held_hex_r <= 8'h00;
    end else if (cfg_valid && cfg_ready) begin
      mode_r  <= cfg_mode;
      phase_r <= PH_PLAIN;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      held_x_r   <= held_x_nxt;
      held_hex_r <= held_hex_nxt;
    end
  end

endmodule

/* rtl/core/bec_queue.sv */
// ----------------------------------------------------------------------------
// bec_queue
// Short first-in first-out queue of classified bundles between front and back.
// ----------------------------------------------------------------------------
module bec_queue
  import bec_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        push_ready,
  input  bec_bundle_t push_data,
  output logic        pop_valid,
  input  logic        pop,
  output bec_bundle_t pop_data
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  bec_bundle_t    mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r;
  logic           do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wrap_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= wrap_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/bec_back.sv */
// ----------------------------------------------------------------------------
// bec_back
// Walk the head bundle one byte per cycle, while the output can take it, into a registered result stage.
// ----------------------------------------------------------------------------
module bec_back
  import bec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_pop,
  input  bec_bundle_t q_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        run_last,
  output logic        text_done
);

  logic [1:0] idx_r;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       bvalid_r, last_r, done_r;
  logic       adv, marker, last;

  assign adv    = q_valid && (!valid_r || out_ready);
  assign marker = (q_data.cnt == '0);
  assign last   = marker || ({1'b0, idx_r} == q_data.cnt - 1'b1);
  assign q_pop  = adv && last;

  always_ff @(posedge clk) begin
    if (adv) begin
      byte_r   <= marker ? 8'h00 : q_data.bytes[idx_r];
      bvalid_r <= !marker;
      last_r   <= last;
      done_r   <= last && q_data.text_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (adv) begin
      valid_r <= 1'b1;
      idx_r   <= last ? '0 : idx_r + 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  assign out_valid  = valid_r;
  assign out_byte   = byte_r;
  assign byte_valid = bvalid_r;
  assign run_last   = last_r;
  assign text_done  = done_r;

endmodule
